/* rtl/nsd_pkg.sv */
// shared types and constants of the nearest seed distance core
`default_nettype none

package nsd_pkg;

    localparam int CFG_W       = 7;
    localparam int SLOT_W      = 6;
    localparam int COORD_W     = 10;
    localparam int QD_W        = 19;
    localparam int SCALE_SHIFT = 16;

    localparam logic [QD_W-1:0] QD_MAX = 19'h7FFFF;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               op;
        logic [SLOT_W-1:0]  slot;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
    } nsd_in_t;

    typedef struct packed {
        logic [QD_W-1:0] quarter_distance;
        logic            empty_res;
    } nsd_out_t;

    typedef struct packed {
        logic valid;
        logic found;
        logic d2_use;
    } nsd_flags_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ROOT
    } nsd_state_t;

endpackage

`default_nettype wire

/* rtl/nsd_cell.sv */
// one chain cell: holds a seed, computes its squared distance, merges the running minimum
`default_nettype none

module nsd_cell #(
    parameter int COORD_BITS = 10,
    parameter int CNT_W      = 7,
    parameter int CELL_IDX   = 0
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          load_en,
    input  wire  [COORD_BITS-1:0]        load_x,
    input  wire  [COORD_BITS-1:0]        load_y,
    input  wire  [CNT_W-1:0]             n_count,
    input  nsd_pkg::nsd_flags_t          in_flags,
    input  wire  [COORD_BITS-1:0]        in_x,
    input  wire  [COORD_BITS-1:0]        in_y,
    input  wire  [2*COORD_BITS:0]        in_best,
    input  wire  [2*COORD_BITS:0]        in_d2,
    output nsd_pkg::nsd_flags_t          out_flags,
    output logic [COORD_BITS-1:0]        out_x,
    output logic [COORD_BITS-1:0]        out_y,
    output logic [2*COORD_BITS:0]        out_best,
    output logic [2*COORD_BITS:0]        out_d2
);

    localparam int D2_W = 2 * COORD_BITS + 1;
    localparam int SQ_W = 2 * COORD_BITS;

    logic [COORD_BITS-1:0] seed_x_reg, seed_y_reg;
    logic [COORD_BITS-1:0] seed_x_next, seed_y_next;
    nsd_pkg::nsd_flags_t   flags_reg, flags_next;
    logic [COORD_BITS-1:0] x_reg, y_reg;
    logic [D2_W-1:0]       best_reg, best_next;
    logic [D2_W-1:0]       d2_reg, d2_next;

    logic [COORD_BITS-1:0] dx, dy;
    logic [SQ_W-1:0]       sq_x, sq_y;
    logic                  take_prev;

    always_comb
    begin
        seed_x_next = load_en ? load_x : seed_x_reg;
        seed_y_next = load_en ? load_y : seed_y_reg;

        dx   = (seed_x_reg > in_x) ? (seed_x_reg - in_x) : (in_x - seed_x_reg);
        dy   = (seed_y_reg > in_y) ? (seed_y_reg - in_y) : (in_y - seed_y_reg);
        sq_x = SQ_W'(dx) * SQ_W'(dx);
        sq_y = SQ_W'(dy) * SQ_W'(dy);
        d2_next = D2_W'(sq_x) + D2_W'(sq_y);

        // fold the previous cell's distance into the running minimum
        take_prev = in_flags.d2_use && (!in_flags.found || (in_d2 < in_best));
        best_next = take_prev ? in_d2 : in_best;

        flags_next.valid  = in_flags.valid;
        flags_next.found  = in_flags.found || in_flags.d2_use;
        flags_next.d2_use = n_count > CNT_W'(CELL_IDX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seed_x_reg <= seed_x_next;
        seed_y_reg <= seed_y_next;
        x_reg      <= in_x;
        y_reg      <= in_y;
        best_reg   <= best_next;
        d2_reg     <= d2_next;
    end

    assign out_flags = flags_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_best  = best_reg;
    assign out_d2    = d2_reg;

endmodule

`default_nettype wire

/* rtl/nsd_sqrt.sv */
// bit-serial integer square root, one result bit per cycle
`default_nettype none

module nsd_sqrt #(
    parameter int RAD_W = 38
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     go,
    input  wire  [RAD_W-1:0]        radicand,
    output logic                    done,
    output logic [RAD_W/2-1:0]      root
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;

    logic [REM_W-1:0]  rem_cat, trial;
    logic              ge, last;

    always_comb
    begin
        rem_cat = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
        trial   = {root_reg, 2'b01};
        ge      = rem_cat >= trial;
        last    = cnt_reg == CNT_W'(ROOT_W - 1);

        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;

        if (go)
        begin
            run_next  = 1'b1;
            cnt_next  = '0;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (run_reg)
        begin
            cnt_next  = cnt_reg + CNT_W'(1);
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            rem_next  = ge ? (rem_cat - trial) : rem_cat;
            root_next = {root_reg[ROOT_W-2:0], ge};
            if (last)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

/* rtl/nearest_seed_distance_core.sv */
// top level of the nearest seed distance core: seed chain, control and root unit
//
// usage:
//   item transfer: item is taken at a rising edge with start high and busy low.
//   a load item (op 0) writes one seed into the chain cell named by slot in that
//   same edge; slots at or above MAX_POINTS are dropped. a load gives no result.
//   a query item (op 1) sends the pixel down the chain of MAX_POINTS cells, one
//   cell per cycle, each cell below point_count folding its seed into a running
//   minimum of squared distance; then a bit-serial root unit makes one result
//   bit per cycle. result transfer: done is high for exactly one cycle with
//   result valid; the receiver cannot stall it.
//   a query result appears once the pixel has passed the chain and the root unit
//   has made its ROOT_W result bits, ROOT_W = COORD_BITS + 9 (19 at defaults);
//   the chain length and the root steps set this; busy is high meanwhile, so
//   no item is taken then; loads and empty queries every cycle while busy is low.
//   with point_count 0 the result (empty_res set) comes in the cycle after the transfer.
//   cfg_we writes point_count from cfg_data; do so only while idle.
//   reset clears point_count and control; seeds are undefined until loaded.
`default_nettype none

module nearest_seed_distance_core #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 10
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           start,
    output logic                          busy,
    input  nsd_pkg::nsd_in_t              item,
    output logic                          done,
    output nsd_pkg::nsd_out_t             result,
    input  wire                           cfg_we,
    input  wire  [nsd_pkg::CFG_W-1:0]     cfg_data
);

    localparam int D2_W    = 2 * COORD_BITS + 1;
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int CW      = (CNT_W > nsd_pkg::CFG_W) ? CNT_W : nsd_pkg::CFG_W;
    localparam int LD_W    = (CNT_W > nsd_pkg::SLOT_W) ? CNT_W : nsd_pkg::SLOT_W;
    localparam int RAD_RAW = D2_W + nsd_pkg::SCALE_SHIFT;
    localparam int RAD_W   = RAD_RAW + (RAD_RAW % 2);
    localparam int ROOT_W  = RAD_W / 2;
    localparam int SAT_W   = (ROOT_W > nsd_pkg::QD_W) ? ROOT_W : nsd_pkg::QD_W;

    logic [nsd_pkg::CFG_W-1:0] point_count_reg, point_count_next;
    nsd_pkg::nsd_state_t       state_reg, state_next;
    logic                      done_reg, done_next;
    nsd_pkg::nsd_out_t         result_reg, result_next;

    logic [CNT_W-1:0]      n_sat;
    logic [CW-1:0]         pc_ext;
    logic [COORD_BITS-1:0] qx, qy;
    logic                  accept, load_fire, query_fire;

    nsd_pkg::nsd_flags_t   ch_flags [MAX_POINTS+1];
    logic [COORD_BITS-1:0] ch_x     [MAX_POINTS+1];
    logic [COORD_BITS-1:0] ch_y     [MAX_POINTS+1];
    logic [D2_W-1:0]       ch_best  [MAX_POINTS+1];
    logic [D2_W-1:0]       ch_d2    [MAX_POINTS+1];

    logic                  take_last;
    logic [D2_W-1:0]       best_final;
    logic                  sqrt_go, sqrt_done;
    logic [RAD_W-1:0]      radicand;
    logic [ROOT_W-1:0]     root;
    logic [SAT_W-1:0]      root_ext;
    logic [nsd_pkg::QD_W-1:0] root_sat;

    // coordinates masked to COORD_BITS
    generate
        if (COORD_BITS >= nsd_pkg::COORD_W)
        begin : g_wide
            assign qx = COORD_BITS'(item.coord_x);
            assign qy = COORD_BITS'(item.coord_y);
        end
        else
        begin : g_narrow
            assign qx = item.coord_x[COORD_BITS-1:0];
            assign qy = item.coord_y[COORD_BITS-1:0];
        end
    endgenerate

    assign busy       = state_reg != nsd_pkg::ST_IDLE;
    assign accept     = start && !busy;
    assign load_fire  = accept && (item.op == nsd_pkg::OP_LOAD);
    assign query_fire = accept && (item.op == nsd_pkg::OP_QUERY);

    assign pc_ext = CW'(point_count_reg);
    assign n_sat  = (pc_ext > CW'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : CNT_W'(pc_ext);

    assign ch_flags[0].valid  = query_fire && (n_sat != '0);
    assign ch_flags[0].found  = 1'b0;
    assign ch_flags[0].d2_use = 1'b0;
    assign ch_x[0]            = qx;
    assign ch_y[0]            = qy;
    assign ch_best[0]         = '0;
    assign ch_d2[0]           = '0;

    generate
        for (genvar i = 0; i < MAX_POINTS; i++)
        begin : g_cell
            nsd_cell #(
                .COORD_BITS (COORD_BITS),
                .CNT_W      (CNT_W),
                .CELL_IDX   (i)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .load_en   (load_fire && (LD_W'(item.slot) == LD_W'(i))),
                .load_x    (qx),
                .load_y    (qy),
                .n_count   (n_sat),
                .in_flags  (ch_flags[i]),
                .in_x      (ch_x[i]),
                .in_y      (ch_y[i]),
                .in_best   (ch_best[i]),
                .in_d2     (ch_d2[i]),
                .out_flags (ch_flags[i+1]),
                .out_x     (ch_x[i+1]),
                .out_y     (ch_y[i+1]),
                .out_best  (ch_best[i+1]),
                .out_d2    (ch_d2[i+1])
            );
        end
    endgenerate

    // last cell's distance still has to be merged
    assign take_last  = ch_flags[MAX_POINTS].d2_use
                        && (!ch_flags[MAX_POINTS].found
                            || (ch_d2[MAX_POINTS] < ch_best[MAX_POINTS]));
    assign best_final = take_last ? ch_d2[MAX_POINTS] : ch_best[MAX_POINTS];
    assign radicand   = RAD_W'({best_final, {nsd_pkg::SCALE_SHIFT{1'b0}}});

    nsd_sqrt #(
        .RAD_W (RAD_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (sqrt_go),
        .radicand (radicand),
        .done     (sqrt_done),
        .root     (root)
    );

    assign root_ext = SAT_W'(root);
    assign root_sat = (root_ext > SAT_W'(nsd_pkg::QD_MAX))
                      ? nsd_pkg::QD_MAX : nsd_pkg::QD_W'(root_ext);

    always_comb
    begin
        point_count_next = cfg_we ? cfg_data : point_count_reg;
        state_next       = state_reg;
        sqrt_go          = 1'b0;
        done_next        = 1'b0;
        result_next      = result_reg;

        case (state_reg)
            nsd_pkg::ST_IDLE:
            begin
                if (query_fire)
                begin
                    if (n_sat == '0)
                    begin
                        done_next                    = 1'b1;
                        result_next.quarter_distance = '0;
                        result_next.empty_res        = 1'b1;
                    end
                    else
                    begin
                        state_next = nsd_pkg::ST_SCAN;
                    end
                end
            end
            nsd_pkg::ST_SCAN:
            begin
                if (ch_flags[MAX_POINTS].valid)
                begin
                    sqrt_go    = 1'b1;
                    state_next = nsd_pkg::ST_ROOT;
                end
            end
            nsd_pkg::ST_ROOT:
            begin
                if (sqrt_done)
                begin
                    done_next                    = 1'b1;
                    result_next.quarter_distance = root_sat;
                    result_next.empty_res        = 1'b0;
                    state_next                   = nsd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nsd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
            state_reg       <= nsd_pkg::ST_IDLE;
            done_reg        <= 1'b0;
        end
        else
        begin
            point_count_reg <= point_count_next;
            state_reg       <= state_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_token_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ch_flags[MAX_POINTS].valid |-> (state_reg == nsd_pkg::ST_SCAN))
        else $error("chain token left the chain outside the scan phase");

    a_query_answered: assert property (@(posedge clk) disable iff (!rst_n)
        query_fire |=> (busy || done))
        else $error("query transfer neither started a scan nor gave a result");

    a_root_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.empty_res) |-> $past(sqrt_done))
        else $error("distance result without a finished root");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.empty_res) |-> (result.quarter_distance == '0))
        else $error("empty result carries a nonzero distance");

endmodule

`default_nettype wire
